// ===== hw/rtl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg
// Types, codes, keyword table and character helpers shared by the shell
// control marker scanner, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package scm_pkg;

	// result kinds
	localparam logic [3:0] KIND_THEN    = 4'd0;
	localparam logic [3:0] KIND_ELIF    = 4'd1;
	localparam logic [3:0] KIND_ELSE    = 4'd2;
	localparam logic [3:0] KIND_IN      = 4'd3;
	localparam logic [3:0] KIND_DO      = 4'd4;
	localparam logic [3:0] KIND_FI      = 4'd5;
	localparam logic [3:0] KIND_DONE    = 4'd6;
	localparam logic [3:0] KIND_ESAC    = 4'd7;
	localparam logic [3:0] KIND_SUMMARY = 4'd8;

	// keyword ids beyond the reported kinds
	localparam logic [3:0] KW_IF    = 4'd8;
	localparam logic [3:0] KW_FOR   = 4'd9;
	localparam logic [3:0] KW_WHILE = 4'd10;
	localparam logic [3:0] KW_UNTIL = 4'd11;
	localparam logic [3:0] KW_CASE  = 4'd12;
	localparam logic [3:0] KW_NONE  = 4'd13;
	localparam int         KW_COUNT = 13;

	// configuration register indexes
	localparam int         CFG_IDX_W        = 1;
	localparam logic [0:0] REG_SCAN_MODE    = 1'b0;
	localparam logic [0:0] REG_MARKER_LIMIT = 1'b1;
	localparam logic [7:0] MARKER_LIMIT_RST = 8'd32;

	// scan modes
	localparam logic MODE_MARKER = 1'b0;
	localparam logic MODE_DEPTH  = 1'b1;

	// quote state
	localparam logic [1:0] Q_NONE   = 2'd0;
	localparam logic [1:0] Q_SINGLE = 2'd1;
	localparam logic [1:0] Q_DOUBLE = 2'd2;

	// pending pair character
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_AMP  = 2'd1;
	localparam logic [1:0] PEND_BAR  = 2'd2;

	// leading phase in marker mode
	localparam logic [1:0] LEAD_BLANKS = 2'd0;
	localparam logic [1:0] LEAD_WORD   = 2'd1;
	localparam logic [1:0] LEAD_DONE   = 2'd2;

	// word buffer limits
	localparam logic [2:0] WORD_KEEP = 3'd5;
	localparam logic [2:0] WORD_LONG = 3'd6;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_BAR    = 8'h7c;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	// keywords, first character in the low byte, zero padded
	localparam logic [39:0] KW_CHARS [KW_COUNT] = '{
		40'h00_6e_65_68_74, // then
		40'h00_66_69_6c_65, // elif
		40'h00_65_73_6c_65, // else
		40'h00_00_00_6e_69, // in
		40'h00_00_00_6f_64, // do
		40'h00_00_00_69_66, // fi
		40'h00_65_6e_6f_64, // done
		40'h00_63_61_73_65, // esac
		40'h00_00_00_66_69, // if
		40'h00_00_72_6f_66, // for
		40'h65_6c_69_68_77, // while
		40'h6c_69_74_6e_75, // until
		40'h00_65_73_61_63  // case
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4,
		3'd2, 3'd3, 3'd5, 3'd5, 3'd4
	};

	// one result item
	typedef struct packed {
		logic [3:0]        kind;
		logic [15:0]       start_offset;
		logic [15:0]       after_offset;
		logic [7:0]        marker_index;
		logic signed [7:0] depth_change;
		logic              construct_closed;
		logic              last;
	} result_t;

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return is_blank(c) || (c == CH_LF);
	endfunction

	function automatic logic is_boundary(input logic [7:0] c);
		return is_space(c) || (c == CH_SEMI) || (c == CH_NUL);
	endfunction

	// keyword id of a buffered word, KW_NONE if none matches
	function automatic logic [3:0] kw_classify(input logic [39:0] chars,
			input logic [2:0] len);
		logic [3:0] id;
		id = KW_NONE;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (chars == KW_CHARS[i] && len == KW_LEN[i])
				id = 4'(i);
		end
		return id;
	endfunction

	// keywords after which a new command starts
	function automatic logic opens_command(input logic [3:0] id);
		return (id == KW_IF) || (id == KIND_ELIF) || (id == KW_WHILE) ||
			(id == KW_UNTIL) || (id == KIND_DO) || (id == KIND_THEN) ||
			(id == KIND_ELSE);
	endfunction

endpackage

// ===== hw/rtl/scm_if.sv =====
// ----------------------------------------------------------------------------
// scm channel interfaces
// Valid/ready channels for text bytes, result items and register writes.
// ----------------------------------------------------------------------------

// text byte channel
interface scm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       first_of_text;

	modport source (output valid, output text_byte, output first_of_text, input ready);
	modport sink (input valid, input text_byte, input first_of_text, output ready);
endinterface

// result channel
interface scm_out_if;
	logic              valid;
	logic              ready;
	logic [3:0]        kind;
	logic [15:0]       start_offset;
	logic [15:0]       after_offset;
	logic [7:0]        marker_index;
	logic signed [7:0] depth_change;
	logic              construct_closed;
	logic              last;

	modport source (output valid, output kind, output start_offset, output after_offset,
		output marker_index, output depth_change, output construct_closed, output last,
		input ready);
	modport sink (input valid, input kind, input start_offset, input after_offset,
		input marker_index, input depth_change, input construct_closed, input last,
		output ready);
endinterface

// register write channel
interface scm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [scm_pkg::CFG_IDX_W-1:0]    index;
	logic [7:0]                       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/shell_control_marker_scanner.sv =====
// ----------------------------------------------------------------------------
// shell_control_marker_scanner
// Scans shell text a byte at a time for control construct markers and
// reports them with offsets, plus one summary per zero-terminated text.
// ----------------------------------------------------------------------------
// The scanner takes one text byte per clock while it does not stall. An
// accepted byte lands in an input register and is scanned by a single pass
// of keyword and flag logic that updates the scan state and writes zero,
// one or two result transactions into a four-entry result queue. Only a
// byte that causes both a marker and the summary puts two results in the
// queue, and since the result port drains one per cycle when ready, the
// input stalls when more than two results are still waiting. With the
// result side always ready a text is scanned at one byte per cycle.
// Registers are written through their own channel, which is always ready;
// the user writes them only between texts; the block does not enforce this.
module shell_control_marker_scanner
	import scm_pkg::*;
#(
	parameter int MAX_TEXT_LENGTH  = 65536,
	parameter int MARKER_LIMIT_MAX = 255
) (
	input  logic clk,
	input  logic arst_n,
	scm_in_if.sink     text_in,
	scm_out_if.source  result_out,
	scm_cfg_if.sink    cfg
);

	localparam int POS_CAP_I = (MAX_TEXT_LENGTH - 1 < 65535) ? MAX_TEXT_LENGTH - 1 : 65535;
	localparam logic [15:0] POS_CAP = 16'(POS_CAP_I);
	localparam int LIM_BITS = $clog2(MARKER_LIMIT_MAX + 1);
	localparam int CMP_W = (LIM_BITS > 8) ? LIM_BITS : 8;
	localparam logic [CMP_W-1:0] LIM_MAX_C = CMP_W'(MARKER_LIMIT_MAX);

	// configuration registers
	logic       scan_mode_q;
	logic [7:0] marker_limit_q;

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// scan state
	logic [1:0]        lead_q;
	logic [1:0]        quote_q;
	logic              cmd_q;
	logic              prev_bnd_q;
	logic [1:0]        pend_q;
	logic [39:0]       wchars_q;
	logic [2:0]        wlen_q;
	logic              wmode_q;
	logic [15:0]       wstart_q;
	logic              wcmd_q;
	logic [15:0]       bpos_q;
	logic signed [7:0] depth_q;
	logic [7:0]        mcnt_q;
	logic              stopped_q;

	// next scan state
	logic [1:0]        lead_d;
	logic [1:0]        quote_d;
	logic              cmd_d;
	logic              prev_bnd_d;
	logic [1:0]        pend_d;
	logic [39:0]       wchars_d;
	logic [2:0]        wlen_d;
	logic              wmode_d;
	logic [15:0]       wstart_d;
	logic              wcmd_d;
	logic [15:0]       bpos_d;
	logic signed [7:0] depth_d;
	logic [7:0]        mcnt_d;
	logic              stopped_d;

	// scan pass working values
	logic [7:0]        c;
	logic [15:0]       pos;
	logic              done;
	logic [7:0]        pair_ch;
	logic [3:0]        kw_id;
	logic              opener;
	logic              closer;
	logic [7:0]        lim;
	logic signed [8:0] sum_depth;
	result_t           res0;
	result_t           res1;
	result_t           sum_res;
	logic [1:0]        nres;

	// result queue
	result_t    fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       proc_fire;
	logic       pop;
	logic [2:0] push_cnt;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q    <= MODE_MARKER;
			marker_limit_q <= MARKER_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SCAN_MODE:    scan_mode_q    <= cfg.data[0];
				REG_MARKER_LIMIT: marker_limit_q <= cfg.data;
			endcase
		end
	end

	// input register
	assign proc_fire     = vld_s1 && (cnt_q <= 3'd2);
	assign text_in.ready = !vld_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (text_in.ready) begin
			vld_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1  <= text_in.text_byte;
			first_s1 <= text_in.first_of_text;
		end
	end

	// effective marker limit
	always_comb begin
		if (CMP_W'(marker_limit_q) < LIM_MAX_C)
			lim = marker_limit_q;
		else
			lim = 8'(MARKER_LIMIT_MAX);
	end

	// scan pass for the byte in the input register
	always_comb begin
		lead_d     = lead_q;
		quote_d    = quote_q;
		cmd_d      = cmd_q;
		prev_bnd_d = prev_bnd_q;
		pend_d     = pend_q;
		wchars_d   = wchars_q;
		wlen_d     = wlen_q;
		wmode_d    = wmode_q;
		wstart_d   = wstart_q;
		wcmd_d     = wcmd_q;
		bpos_d     = bpos_q;
		depth_d    = depth_q;
		mcnt_d     = mcnt_q;
		stopped_d  = stopped_q;
		c          = byte_s1;
		done       = 1'b0;
		pair_ch    = CH_AMP;
		kw_id      = KW_NONE;
		opener     = 1'b0;
		closer     = 1'b0;
		sum_depth  = '0;
		res0       = '0;
		res1       = '0;
		sum_res    = '0;
		nres       = 2'd0;

		// restart on the first byte of a text
		if (first_s1) begin
			lead_d    = LEAD_BLANKS;
			quote_d   = Q_NONE;
			cmd_d     = 1'b1;
			prev_bnd_d = 1'b1;
			pend_d    = PEND_NONE;
			wchars_d  = '0;
			wlen_d    = '0;
			wmode_d   = 1'b0;
			wstart_d  = '0;
			wcmd_d    = 1'b0;
			bpos_d    = '0;
			depth_d   = (scan_mode_q == MODE_MARKER) ? 8'sd1 : 8'sd0;
			mcnt_d    = '0;
			stopped_d = 1'b0;
		end
		pos = bpos_d;

		if (!stopped_d) begin
			// inside quotes only the closing quote matters
			if (quote_d != Q_NONE) begin
				if (c == ((quote_d == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE))
					quote_d = Q_NONE;
				done = 1'b1;
			end

			// second half of && or ||
			if (!done && pend_d != PEND_NONE) begin
				pair_ch = (pend_d == PEND_AMP) ? CH_AMP : CH_BAR;
				pend_d  = PEND_NONE;
				if (c == pair_ch) begin
					cmd_d = 1'b1;
					done  = 1'b1;
				end else begin
					cmd_d = 1'b0;
				end
			end

			// word in progress: extend it or finish it
			if (!done && wmode_d) begin
				if (is_ident(c)) begin
					if (wlen_d < WORD_KEEP)
						wchars_d = wchars_d | (40'(c) << {wlen_d, 3'b000});
					if (wlen_d < WORD_LONG)
						wlen_d = wlen_d + 3'd1;
					done = 1'b1;
				end else begin
					wmode_d = 1'b0;
					if (!is_boundary(c)) begin
						cmd_d = 1'b0;
					end else begin
						kw_id  = kw_classify(wchars_d, wlen_d);
						opener = (kw_id >= KW_IF) && (kw_id <= KW_CASE);
						closer = (kw_id >= KIND_FI) && (kw_id <= KIND_ESAC);
						if (scan_mode_q == MODE_MARKER) begin
							if (opener) begin
								if (wcmd_d && depth_d < 8'sd127)
									depth_d = depth_d + 8'sd1;
							end else if (closer) begin
								if (wcmd_d) begin
									if (depth_d != -8'sd128)
										depth_d = depth_d - 8'sd1;
									if (depth_d == 8'sd0) begin
										if (mcnt_d < lim) begin
											res0.kind         = kw_id;
											res0.start_offset = wstart_d;
											res0.after_offset = pos;
											res0.marker_index = mcnt_d;
											nres              = 2'd1;
											mcnt_d            = mcnt_d + 8'd1;
										end
										stopped_d = 1'b1;
									end
								end
							end else if (depth_d == 8'sd1 && kw_id <= KIND_DO && mcnt_d < lim) begin
								res0.kind         = kw_id;
								res0.start_offset = wstart_d;
								res0.after_offset = pos;
								res0.marker_index = mcnt_d;
								nres              = 2'd1;
								mcnt_d            = mcnt_d + 8'd1;
							end
							cmd_d = opens_command(kw_id);
						end else begin
							if (wcmd_d) begin
								if (opener && depth_d < 8'sd127)
									depth_d = depth_d + 8'sd1;
								else if (closer && depth_d != -8'sd128)
									depth_d = depth_d - 8'sd1;
							end
							cmd_d = wcmd_d && opens_command(kw_id);
						end
					end
					if (stopped_d)
						done = 1'b1;
				end
			end

			// marker mode skips leading blanks and the first word
			if (!done && scan_mode_q == MODE_MARKER && lead_d != LEAD_DONE) begin
				if (lead_d == LEAD_BLANKS) begin
					if (is_space(c))
						done = 1'b1;
					else
						lead_d = LEAD_WORD;
				end
				if (!done) begin
					if (is_ident(c))
						done = 1'b1;
					else
						lead_d = LEAD_DONE;
				end
			end

			// ordinary byte
			if (!done && c != CH_NUL) begin
				if (c == CH_SQUOTE || c == CH_DQUOTE) begin
					quote_d = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
					cmd_d   = 1'b0;
				end else if (c == CH_SEMI || c == CH_LF) begin
					cmd_d = 1'b1;
				end else if (c == CH_AMP || c == CH_BAR) begin
					pend_d = (c == CH_AMP) ? PEND_AMP : PEND_BAR;
				end else if (is_blank(c)) begin
					cmd_d = cmd_d;
				end else if (is_ident(c) && prev_bnd_d) begin
					wmode_d  = 1'b1;
					wchars_d = 40'(c);
					wlen_d   = 3'd1;
					wstart_d = pos;
					wcmd_d   = cmd_d;
				end else begin
					cmd_d = 1'b0;
				end
			end
		end

		prev_bnd_d = is_boundary(c);
		bpos_d     = (pos < POS_CAP) ? pos + 16'd1 : POS_CAP;

		// zero byte: summary and restart
		if (c == CH_NUL) begin
			sum_depth = {depth_d[7], depth_d};
			if (scan_mode_q == MODE_MARKER)
				sum_depth = sum_depth - 9'sd1;
			sum_res.kind             = KIND_SUMMARY;
			sum_res.after_offset     = pos;
			sum_res.marker_index     = mcnt_d;
			sum_res.depth_change     = (sum_depth < -9'sd128) ? -8'sd128 : sum_depth[7:0];
			sum_res.construct_closed = (scan_mode_q == MODE_MARKER) && stopped_d;
			if (nres == 2'd0)
				res0 = sum_res;
			else
				res1 = sum_res;
			nres = nres + 2'd1;

			lead_d     = LEAD_BLANKS;
			quote_d    = Q_NONE;
			cmd_d      = 1'b1;
			prev_bnd_d = 1'b1;
			pend_d     = PEND_NONE;
			wchars_d   = '0;
			wlen_d     = '0;
			wmode_d    = 1'b0;
			wstart_d   = '0;
			wcmd_d     = 1'b0;
			bpos_d     = '0;
			depth_d    = (scan_mode_q == MODE_MARKER) ? 8'sd1 : 8'sd0;
			mcnt_d     = '0;
			stopped_d  = 1'b0;
		end

		// mark the final result of this byte
		if (nres == 2'd1)
			res0.last = 1'b1;
		else if (nres == 2'd2)
			res1.last = 1'b1;
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= LEAD_BLANKS;
			quote_q    <= Q_NONE;
			cmd_q      <= 1'b1;
			prev_bnd_q <= 1'b1;
			pend_q     <= PEND_NONE;
			wchars_q   <= '0;
			wlen_q     <= '0;
			wmode_q    <= 1'b0;
			wstart_q   <= '0;
			wcmd_q     <= 1'b0;
			bpos_q     <= '0;
			depth_q    <= 8'sd1;
			mcnt_q     <= '0;
			stopped_q  <= 1'b0;
		end else if (proc_fire) begin
			lead_q     <= lead_d;
			quote_q    <= quote_d;
			cmd_q      <= cmd_d;
			prev_bnd_q <= prev_bnd_d;
			pend_q     <= pend_d;
			wchars_q   <= wchars_d;
			wlen_q     <= wlen_d;
			wmode_q    <= wmode_d;
			wstart_q   <= wstart_d;
			wcmd_q     <= wcmd_d;
			bpos_q     <= bpos_d;
			depth_q    <= depth_d;
			mcnt_q     <= mcnt_d;
			stopped_q  <= stopped_d;
		end
	end

	// result queue
	assign pop      = result_out.valid && result_out.ready;
	assign push_cnt = proc_fire ? {1'b0, nres} : 3'd0;

	always_ff @(posedge clk) begin
		if (proc_fire && nres != 2'd0)
			fifo_q[wr_ptr_q] <= res0;
		if (proc_fire && nres == 2'd2)
			fifo_q[wr_ptr_q + 2'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[1:0];
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + push_cnt - {2'b00, pop};
		end
	end

	// result port
	assign result_out.valid            = (cnt_q != 3'd0);
	assign result_out.kind             = fifo_q[rd_ptr_q].kind;
	assign result_out.start_offset     = fifo_q[rd_ptr_q].start_offset;
	assign result_out.after_offset     = fifo_q[rd_ptr_q].after_offset;
	assign result_out.marker_index     = fifo_q[rd_ptr_q].marker_index;
	assign result_out.depth_change     = fifo_q[rd_ptr_q].depth_change;
	assign result_out.construct_closed = fifo_q[rd_ptr_q].construct_closed;
	assign result_out.last             = fifo_q[rd_ptr_q].last;

endmodule

// ===== hw/rtl/scm_checker.sv =====
// ----------------------------------------------------------------------------
// scm_checker
// Port-level checks on the result channel of the marker scanner, bound to
// the scanner module.
// ----------------------------------------------------------------------------
module scm_checker
	import scm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [3:0]        out_kind,
	input logic [15:0]       out_start,
	input logic [15:0]       out_after,
	input logic [7:0]        out_index,
	input logic signed [7:0] out_depth,
	input logic              out_closed,
	input logic              out_last
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_kind, out_start, out_after, out_index, out_depth, out_closed, out_last}))
		else $error("result changed while stalled");

	// the summary is always the final result of its byte and has start offset zero
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_SUMMARY |-> out_last && out_start == 16'd0)
		else $error("summary not last or start offset nonzero");

	// markers carry no depth or closed flag
	a_marker_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_SUMMARY |-> out_depth == 8'sd0 && !out_closed)
		else $error("marker carries summary fields");

	// a result that is not last is followed by the summary of the same byte
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_kind == KIND_SUMMARY)
		else $error("marker not followed by summary");

endmodule

bind shell_control_marker_scanner scm_checker u_scm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_kind   (result_out.kind),
	.out_start  (result_out.start_offset),
	.out_after  (result_out.after_offset),
	.out_index  (result_out.marker_index),
	.out_depth  (result_out.depth_change),
	.out_closed (result_out.construct_closed),
	.out_last   (result_out.last)
);

// ===== tb/sv/tb_shell_control_marker_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_control_marker_scanner
// Feeds shell texts into the control marker scanner and compares every result
// transaction with a cycle-free model of the scan kept inside this bench.
// Directed texts cover keywords, quoting, operator pairs, limits, restarts,
// mode changes and saturation; random texts follow under three idle patterns.
// ----------------------------------------------------------------------------
module tb_shell_control_marker_scanner;
	import scm_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 150;

	// keyword spellings, first character most significant
	localparam logic [39:0] WORD_THEN  = "then";
	localparam logic [39:0] WORD_ELIF  = "elif";
	localparam logic [39:0] WORD_ELSE  = "else";
	localparam logic [39:0] WORD_IN    = "in";
	localparam logic [39:0] WORD_DO    = "do";
	localparam logic [39:0] WORD_FI    = "fi";
	localparam logic [39:0] WORD_DONE  = "done";
	localparam logic [39:0] WORD_ESAC  = "esac";
	localparam logic [39:0] WORD_IF    = "if";
	localparam logic [39:0] WORD_FOR   = "for";
	localparam logic [39:0] WORD_WHILE = "while";
	localparam logic [39:0] WORD_UNTIL = "until";
	localparam logic [39:0] WORD_CASE  = "case";

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scm_in_if  text_in ();
	scm_out_if result_out ();
	scm_cfg_if cfg ();

	shell_control_marker_scanner DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// bench control
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int error_count = 0;
	int active_items = 0;
	int cycle_count = 0;
	bit text_open = 1'b0;
	logic [7:0] text_buf [$];
	result_t expected_results [$];
	result_t batch [2];
	int batch_n;

	// copy of the configuration and of the scan state
	logic        cfg_depth_mode;
	logic [7:0]  cfg_marker_limit;
	logic [1:0]  lead_state;
	logic [1:0]  quote_state;
	bit          at_command;
	bit          after_boundary;
	logic [1:0]  pair_pending;
	logic [39:0] word_bits;
	int          word_len;
	bit          in_word;
	logic [15:0] word_begin;
	bit          word_at_command;
	logic [15:0] position;
	int          nest_depth;
	logic [7:0]  markers_sent;
	bit          scan_closed;

	string keyword_words [13] = '{"then", "elif", "else", "in", "do", "fi", "done", "esac",
		"if", "for", "while", "until", "case"};
	string openers [5] = '{"if", "for", "while", "until", "case"};
	string separators [6] = '{"; ", "\n", ";", " ", " && ", " || "};
	string pair_ops [4] = '{"&&", "||", " & ", "|"};
	string blanks [4] = '{" ", "\t", "\n", "\r"};
	string punct = "()$-=<>{}!#*.,";

	// ------------------------------------------------------------------
	// scan model
	// ------------------------------------------------------------------

	function automatic bit word_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "_";
	endfunction

	function automatic bit white(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit separator(input logic [7:0] c);
		return white(c) || c == CH_SEMI || c == CH_NUL;
	endfunction

	function automatic logic [3:0] keyword_of(input logic [39:0] w, input int n);
		if (n > 5)
			return KW_NONE;
		case (w)
			WORD_THEN:  return KIND_THEN;
			WORD_ELIF:  return KIND_ELIF;
			WORD_ELSE:  return KIND_ELSE;
			WORD_IN:    return KIND_IN;
			WORD_DO:    return KIND_DO;
			WORD_FI:    return KIND_FI;
			WORD_DONE:  return KIND_DONE;
			WORD_ESAC:  return KIND_ESAC;
			WORD_IF:    return KW_IF;
			WORD_FOR:   return KW_FOR;
			WORD_WHILE: return KW_WHILE;
			WORD_UNTIL: return KW_UNTIL;
			WORD_CASE:  return KW_CASE;
			default:    return KW_NONE;
		endcase
	endfunction

	// keywords that leave the next word in command position
	function automatic bit starts_command(input logic [3:0] id);
		return id == KW_IF || id == KIND_ELIF || id == KW_WHILE || id == KW_UNTIL ||
			id == KIND_DO || id == KIND_THEN || id == KIND_ELSE;
	endfunction

	function automatic void restart_scan();
		lead_state = LEAD_BLANKS;
		quote_state = Q_NONE;
		at_command = 1'b1;
		after_boundary = 1'b1;
		pair_pending = PEND_NONE;
		word_bits = '0;
		word_len = 0;
		in_word = 1'b0;
		word_begin = '0;
		word_at_command = 1'b0;
		position = '0;
		nest_depth = (cfg_depth_mode == MODE_MARKER) ? 1 : 0;
		markers_sent = '0;
		scan_closed = 1'b0;
	endfunction

	function automatic void add_result(input logic [3:0] kind, input logic [15:0] start,
			input logic [15:0] after, input logic [7:0] idx, input logic [7:0] dchg,
			input logic closed);
		result_t r;
		r.kind = kind;
		r.start_offset = start;
		r.after_offset = after;
		r.marker_index = idx;
		r.depth_change = dchg;
		r.construct_closed = closed;
		r.last = 1'b0;
		batch[batch_n] = r;
		batch_n++;
	endfunction

	function automatic void add_marker(input logic [3:0] id);
		add_result(id, word_begin, position, markers_sent, 8'd0, 1'b0);
		markers_sent++;
	endfunction

	// a word in progress meets a non-identifier byte
	function automatic void close_word(input logic [7:0] c);
		logic [3:0] id;
		bit opener;
		bit closer;
		in_word = 1'b0;
		if (!separator(c)) begin
			at_command = 1'b0;
			return;
		end
		id = keyword_of(word_bits, word_len);
		opener = id >= KW_IF && id <= KW_CASE;
		closer = id >= KIND_FI && id <= KIND_ESAC;
		if (cfg_depth_mode == MODE_MARKER) begin
			if (opener) begin
				if (word_at_command && nest_depth < 127)
					nest_depth++;
			end else if (closer) begin
				if (word_at_command) begin
					if (nest_depth > -128)
						nest_depth--;
					if (nest_depth == 0) begin
						if (markers_sent < cfg_marker_limit)
							add_marker(id);
						scan_closed = 1'b1;
					end
				end
			end else if (nest_depth == 1 && id <= KIND_DO && markers_sent < cfg_marker_limit) begin
				add_marker(id);
			end
			at_command = starts_command(id);
		end else begin
			if (word_at_command) begin
				if (opener && nest_depth < 127)
					nest_depth++;
				else if (closer && nest_depth > -128)
					nest_depth--;
			end
			at_command = word_at_command && starts_command(id);
		end
	endfunction

	// byte outside quotes, words and the leading phase
	function automatic void plain_byte(input logic [7:0] c);
		if (c == CH_SQUOTE || c == CH_DQUOTE) begin
			quote_state = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
			at_command = 1'b0;
		end else if (c == CH_SEMI || c == CH_LF) begin
			at_command = 1'b1;
		end else if (c == CH_AMP || c == CH_BAR) begin
			pair_pending = (c == CH_AMP) ? PEND_AMP : PEND_BAR;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
			// blanks leave the state alone
		end else if (word_char(c) && after_boundary) begin
			in_word = 1'b1;
			word_bits = {32'd0, c};
			word_len = 1;
			word_begin = position;
			word_at_command = at_command;
		end else begin
			at_command = 1'b0;
		end
	endfunction

	function automatic void scan_active(input logic [7:0] c);
		// quoted span
		if (quote_state != Q_NONE) begin
			if ((quote_state == Q_SINGLE && c == CH_SQUOTE) ||
					(quote_state == Q_DOUBLE && c == CH_DQUOTE))
				quote_state = Q_NONE;
			return;
		end
		// second half of && or ||
		if (pair_pending != PEND_NONE) begin
			if ((pair_pending == PEND_AMP && c == CH_AMP) ||
					(pair_pending == PEND_BAR && c == CH_BAR)) begin
				pair_pending = PEND_NONE;
				at_command = 1'b1;
				return;
			end
			pair_pending = PEND_NONE;
			at_command = 1'b0;
		end
		// word in progress
		if (in_word) begin
			if (word_char(c)) begin
				if (word_len < 5)
					word_bits = {word_bits[31:0], c};
				if (word_len < 6)
					word_len++;
				return;
			end
			close_word(c);
			if (scan_closed)
				return;
		end
		// leading blanks and first word in marker mode
		if (cfg_depth_mode == MODE_MARKER && lead_state != LEAD_DONE) begin
			if (lead_state == LEAD_BLANKS) begin
				if (white(c))
					return;
				lead_state = LEAD_WORD;
			end
			if (word_char(c))
				return;
			lead_state = LEAD_DONE;
		end
		if (c != CH_NUL)
			plain_byte(c);
	endfunction

	// one accepted byte, returns whether the scan was still live
	function automatic bit scan_byte(input logic [7:0] c, input logic first);
		logic [15:0] pos;
		int summary_depth;
		bit active;
		batch_n = 0;
		if (first)
			restart_scan();
		pos = position;
		active = !scan_closed;
		if (active)
			scan_active(c);
		after_boundary = separator(c);
		position = (pos < 16'hffff) ? pos + 16'd1 : pos;
		if (c == CH_NUL) begin
			summary_depth = (cfg_depth_mode == MODE_MARKER) ? nest_depth - 1 : nest_depth;
			if (summary_depth < -128)
				summary_depth = -128;
			add_result(KIND_SUMMARY, 16'd0, pos, markers_sent, 8'(summary_depth),
				(cfg_depth_mode == MODE_MARKER) && scan_closed);
			restart_scan();
		end
		for (int i = 0; i < batch_n; i++) begin
			if (i == batch_n - 1)
				batch[i].last = 1'b1;
			expected_results.push_back(batch[i]);
		end
		return active;
	endfunction

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// ready with random stalls and requested long hold-offs
	initial begin : result_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (!arst_n) begin
				result_out.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with none expected: kind %0d", result_out.kind);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("kind", int'(want.kind), int'(result_out.kind));
				compare_field("start_offset", int'(want.start_offset),
					int'(result_out.start_offset));
				compare_field("after_offset", int'(want.after_offset),
					int'(result_out.after_offset));
				compare_field("marker_index", int'(want.marker_index),
					int'(result_out.marker_index));
				compare_field("depth_change", int'(want.depth_change),
					int'(result_out.depth_change));
				compare_field("construct_closed", int'(want.construct_closed),
					int'(result_out.construct_closed));
				compare_field("last", int'(want.last), int'(result_out.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout with %0d results outstanding", expected_results.size());
			$display("FAIL shell_control_marker_scanner");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic send_byte(input logic [7:0] c, input logic first);
		if ($urandom_range(99) < send_idle_pct) begin
			text_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		text_in.valid <= 1'b1;
		text_in.text_byte <= c;
		text_in.first_of_text <= first;
		do @(posedge clk); while (!text_in.ready);
		if (scan_byte(c, first))
			active_items++;
	endtask

	// stop sending and wait for every expected result plus the pipeline
	task automatic wait_idle();
		text_in.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic mode, input logic [7:0] limit);
		cfg.valid <= 1'b1;
		cfg.index <= REG_SCAN_MODE;
		cfg.data <= {7'd0, mode};
		do @(posedge clk); while (!cfg.ready);
		cfg_depth_mode = mode;
		cfg.index <= REG_MARKER_LIMIT;
		cfg.data <= limit;
		do @(posedge clk); while (!cfg.ready);
		cfg_marker_limit = limit;
		cfg.valid <= 1'b0;
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	task automatic send_buf(input bit fresh, input int restart_pct);
		foreach (text_buf[i])
			send_byte(text_buf[i], (i == 0 && fresh) || $urandom_range(999) < restart_pct);
	endtask

	task automatic send_line(input string s, input bit fresh, input bit terminate);
		text_buf.delete();
		add_text(s);
		if (terminate)
			text_buf.push_back(CH_NUL);
		send_buf(fresh, 0);
	endtask

	function automatic string random_word();
		string s;
		int pick;
		s = "";
		repeat ($urandom_range(1, 8)) begin
			pick = $urandom_range(0, 62);
			if (pick < 26)
				s = {s, $sformatf("%c", 8'("a") + 8'(pick))};
			else if (pick < 52)
				s = {s, $sformatf("%c", 8'("A") + 8'(pick - 26))};
			else if (pick < 62)
				s = {s, $sformatf("%c", 8'("0") + 8'(pick - 52))};
			else
				s = {s, "_"};
		end
		return s;
	endfunction

	function automatic logic [7:0] random_punct();
		return punct[$urandom_range(0, punct.len() - 1)];
	endfunction

	task automatic add_token();
		logic [7:0] q;
		logic [7:0] b;
		case ($urandom_range(0, 13))
			0, 1, 2: begin
				add_text(separators[$urandom_range(0, 5)]);
				add_text(keyword_words[$urandom_range(0, 12)]);
			end
			3: add_text(keyword_words[$urandom_range(0, 12)]);
			4, 5: add_text(random_word());
			6, 7: add_text(separators[$urandom_range(0, 5)]);
			8: add_text(pair_ops[$urandom_range(0, 3)]);
			9: begin
				// quoted span, sometimes left open
				q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
				text_buf.push_back(q);
				repeat ($urandom_range(0, 5)) begin
					b = 8'($urandom_range(1, 255));
					text_buf.push_back((b == q) ? 8'h78 : b);
				end
				if ($urandom_range(99) < 85)
					text_buf.push_back(q);
			end
			10: text_buf.push_back(random_punct());
			11: text_buf.push_back(8'($urandom_range(1, 255)));
			12: begin
				add_text(keyword_words[$urandom_range(0, 12)]);
				text_buf.push_back(random_punct());
			end
			default: add_text(" ");
		endcase
	endtask

	// mostly well-formed constructs with random content, some noise
	task automatic build_random_text(output bit terminated);
		text_buf.delete();
		if ($urandom_range(99) < 80) begin
			repeat ($urandom_range(0, 2)) add_text(blanks[$urandom_range(0, 3)]);
			if ($urandom_range(99) < 85)
				add_text(openers[$urandom_range(0, 4)]);
			else
				add_text(random_word());
			add_text(" ");
			repeat ($urandom_range(2, 16)) add_token();
			if ($urandom_range(99) < 70) begin
				add_text(separators[$urandom_range(0, 5)]);
				add_text(keyword_words[$urandom_range(5, 7)]);
			end
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(1, 4)) add_token();
		end else begin
			repeat ($urandom_range(0, 12)) text_buf.push_back(8'($urandom_range(1, 255)));
		end
		terminated = $urandom_range(99) < 95;
		if (terminated)
			text_buf.push_back(CH_NUL);
	endtask

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(0, 6))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd255;
			4: return MARKER_LIMIT_RST;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_markers();
		wait_idle();
		write_config(MODE_MARKER, 8'd255);
		send_line("if a; then b && c || d; elif e & f | g; then 'fi' \"done\"; else h; fi",
			1'b1, 1'b1);
		send_line(" \twhile x; do for i in a b; do y; done; done tail", 1'b1, 1'b1);
		send_line("case v in a) x;; esac", 1'b1, 1'b1);
		// long words and words glued to punctuation
		send_line("if thenelse; then- x; whiles; elsewhere;then_x; until\n elif\xff\x80;fi",
			1'b1, 1'b1);
	endtask

	task automatic test_marker_limit();
		wait_idle();
		write_config(MODE_MARKER, 8'd0);
		send_line("if a; then b; fi", 1'b1, 1'b1);
		wait_idle();
		write_config(MODE_MARKER, 8'd1);
		send_line("if a; then b; else c; fi; then x", 1'b1, 1'b1);
	endtask

	task automatic test_depth_mode();
		wait_idle();
		write_config(MODE_DEPTH, 8'd32);
		send_line("if a; then for x in y; do z; done; fi; case q in esac; while", 1'b1, 1'b1);
		send_line("  echo if; fi fi;fi a&&until b||case", 1'b1, 1'b1);
	endtask

	task automatic test_restart();
		wait_idle();
		write_config(MODE_MARKER, 8'd4);
		send_line("if a; then b", 1'b1, 1'b0);
		send_line("x y; then z", 1'b1, 1'b1);
		// zero byte restarts on its own
		send_line("for i in j; do k; done", 1'b0, 1'b1);
		// open quote and pending operator at the end
		send_line("if 'then", 1'b1, 1'b1);
		send_line("if a; then b &", 1'b1, 1'b1);
		send_line("", 1'b1, 1'b1);
	endtask

	task automatic test_mode_switch();
		wait_idle();
		write_config(MODE_MARKER, 8'd255);
		send_line("x if a; ", 1'b1, 1'b0);
		wait_idle();
		write_config(MODE_DEPTH, 8'd255);
		send_line("then fi; fi; if", 1'b0, 1'b1);
		send_line("if a; ", 1'b1, 1'b0);
		wait_idle();
		write_config(MODE_MARKER, 8'd255);
		send_line("then b; fi; else c", 1'b0, 1'b1);
	endtask

	task automatic test_saturation();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// depth is driven past its bottom value and saturates there
		wait_idle();
		write_config(MODE_DEPTH, 8'd255);
		text_buf.delete();
		repeat (130) add_text("fi;");
		send_buf(1'b1, 0);
		// marker mode summary of that depth clamps as well
		wait_idle();
		write_config(MODE_MARKER, 8'd255);
		send_line("", 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_idle();
		write_config(MODE_MARKER, 8'd255);
		// summaries pile up behind a long stall
		hold_requests++;
		repeat (16) send_byte(CH_NUL, 1'b1);
		wait_idle();
		// bytes with a marker and a summary each
		hold_requests++;
		repeat (6) send_line("x then", 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_texts(input int send_pct, input int recv_pct, input int items);
		int target;
		bit terminated;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = active_items + items;
		while (active_items < target) begin
			if (!text_open && $urandom_range(99) < 8) begin
				wait_idle();
				write_config(1'($urandom_range(0, 1)), pick_limit());
			end
			build_random_text(terminated);
			send_buf(text_open || $urandom_range(99) < 90, 5);
			text_open = !terminated;
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		text_in.valid <= 1'b0;
		text_in.text_byte <= CH_NUL;
		text_in.first_of_text <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_SCAN_MODE;
		cfg.data <= 8'd0;
		cfg_depth_mode = MODE_MARKER;
		cfg_marker_limit = MARKER_LIMIT_RST;
		restart_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 76;
		test_markers();
		test_marker_limit();
		test_depth_mode();
		test_restart();
		test_mode_switch();
		test_backpressure();
		test_saturation();
		test_random_texts(18, 76, 40);
		test_random_texts(76, 18, 40);
		test_random_texts(0, 0, 40);
		wait_idle();

		if (error_count == 0)
			$display("PASS shell_control_marker_scanner");
		else
			$display("FAIL shell_control_marker_scanner");
		$finish;
	end

endmodule
